// File: rtl/core/tvgs_pkg.sv
package tvgs_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned COL_W      = 11;
  localparam int unsigned ROW_W      = 13;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned FRAC_W     = 14;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic signed [COEF_W-1:0] BINOM_SIDE   = 18'sd4096;
  localparam logic signed [COEF_W-1:0] BINOM_CENTRE = 18'sd8192;
  localparam logic signed [COEF_W-1:0] SIDE_RESET   = -18'sd4096;
  localparam logic signed [COEF_W-1:0] CENTRE_RESET = 18'sd24576;

  typedef logic [2:0][WORD_W-1:0] vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION    = 3'd0,
    REG_FILTER_MODE  = 3'd1,
    REG_ACTIVE_WIDTH = 3'd2,
    REG_ACTIVE_ROWS  = 3'd3,
    REG_SIDE_COEF    = 3'd4,
    REG_CENTER_COEF  = 3'd5
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_BYPASS      = 2'd0,
    MODE_BINOMIAL    = 2'd1,
    MODE_COMPENSATED = 2'd2
  } mode_e;

  typedef struct packed {
    vec_t lo;
    vec_t mid;
    vec_t up;
    logic row_end;
    logic frame_end;
  } window_t;

endpackage

// File: rtl/core/tvgs_if.sv
interface tvgs_cell_if;
  import tvgs_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] cell_x;
  logic [WORD_W-1:0] cell_y;
  logic [WORD_W-1:0] cell_z;
  logic              frame_start;

  modport source (output valid, cell_x, cell_y, cell_z, frame_start, input ready);
  modport sink   (input valid, cell_x, cell_y, cell_z, frame_start, output ready);
endinterface

interface tvgs_res_if;
  import tvgs_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_x;
  logic [WORD_W-1:0] out_y;
  logic [WORD_W-1:0] out_z;
  logic              row_end;
  logic              frame_end;

  modport source (output valid, out_x, out_y, out_z, row_end, frame_end, input ready);
  modport sink   (input valid, out_x, out_y, out_z, row_end, frame_end, output ready);
endinterface

// File: rtl/core/tvgs_ram.sv
module tvgs_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/tvgs_window.sv
module tvgs_window import tvgs_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_ROWS  = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tvgs_cell_if.sink        cell_i,
  input  logic             direction_i,
  input  logic [COL_W-1:0] active_width_i,
  input  logic [ROW_W-1:0] active_rows_i,
  output logic             win_valid_o,
  input  logic             win_ready_i,
  output window_t          win_o
);

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned WLIM  = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
  localparam int unsigned RLIM  = (MAX_ROWS > 8191) ? 8191 : MAX_ROWS;
  localparam logic [COL_W-1:0] WLIM_V = COL_W'(WLIM);
  localparam logic [ROW_W-1:0] RLIM_V = ROW_W'(RLIM);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  vec_t             left_q, centre_q;

  logic             s1_v_q;
  logic             s1_prod_q;
  logic             s1_wr_q;
  logic             s1_fwd_q;
  logic [AW-1:0]    s1_idx_q;
  vec_t             s1_cur_q, s1_l_q, s1_c_q, s1_fmid_q, s1_flow_q;
  logic             s1_re_q, s1_fe_q;

  logic             accept, s1_leave;
  vec_t             cur;
  logic [COL_W-1:0] col_cur, w_eff, lastc_lim;
  logic [ROW_W-1:0] row_cur, r_eff;
  logic [ROW_W:0]   lastr_lim;
  logic             lastc, lastr, prod;
  logic [COL_W-1:0] idx_full;
  logic [AW-1:0]    idx;
  logic             fwd_d;
  vec_t             low_rd, mid_rd, low_eff, mid_eff;

  assign cur      = {cell_i.cell_z, cell_i.cell_y, cell_i.cell_x};
  assign s1_leave = s1_v_q && (!s1_prod_q || win_ready_i);
  assign cell_i.ready = !s1_v_q || s1_leave;
  assign accept   = cell_i.valid && cell_i.ready;

  always_comb begin
    col_cur = cell_i.frame_start ? '0 : col_q;
    row_cur = cell_i.frame_start ? '0 : row_q;

    w_eff = (active_width_i == '0) ? COL_W'(1) : active_width_i;
    if (w_eff > WLIM_V) begin
      w_eff = WLIM_V;
    end
    r_eff = (active_rows_i == '0) ? ROW_W'(1) : active_rows_i;
    if (r_eff > RLIM_V) begin
      r_eff = RLIM_V;
    end

    if (!direction_i) begin
      lastc_lim = w_eff + COL_W'(1);
      lastr_lim = {1'b0, r_eff} + (ROW_W+1)'(2);
    end else begin
      lastc_lim = w_eff - COL_W'(1);
      lastr_lim = {1'b0, r_eff} + (ROW_W+1)'(1);
    end
    lastc = {1'b0, col_cur} >= {1'b0, lastc_lim};
    lastr = {1'b0, row_cur} >= lastr_lim;

    idx_full = (col_cur < w_eff) ? col_cur : (w_eff - COL_W'(1));
    idx      = AW'(idx_full);

    prod = direction_i ? (row_cur >= ROW_W'(2)) : (col_cur >= COL_W'(2));

    if (lastc) begin
      col_d = '0;
      row_d = lastr ? '0 : (row_cur + ROW_W'(1));
    end else begin
      col_d = col_cur + COL_W'(1);
      row_d = row_cur;
    end

    fwd_d = direction_i && s1_v_q && s1_wr_q && (s1_idx_q == idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
      centre_q <= '0;
      s1_v_q   <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        if (!direction_i) begin
          left_q   <= centre_q;
          centre_q <= cur;
        end
        s1_v_q <= 1'b1;
      end else if (s1_leave) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_prod_q <= prod;
      s1_wr_q   <= direction_i;
      s1_fwd_q  <= fwd_d;
      s1_idx_q  <= idx;
      s1_cur_q  <= cur;
      s1_l_q    <= left_q;
      s1_c_q    <= centre_q;
      s1_fmid_q <= s1_cur_q;
      s1_flow_q <= mid_eff;
      s1_re_q   <= lastc;
      s1_fe_q   <= lastc && lastr;
    end
  end

  assign mid_eff = s1_fwd_q ? s1_fmid_q : mid_rd;
  assign low_eff = s1_fwd_q ? s1_flow_q : low_rd;

  tvgs_ram #(
    .WIDTH ($bits(vec_t)),
    .DEPTH (MAX_WIDTH)
  ) u_lower_line (
    .clk_i   (clk_i),
    .we_i    (s1_leave && s1_wr_q),
    .waddr_i (s1_idx_q),
    .wdata_i (mid_eff),
    .re_i    (accept && direction_i),
    .raddr_i (idx),
    .rdata_o (low_rd)
  );

  tvgs_ram #(
    .WIDTH ($bits(vec_t)),
    .DEPTH (MAX_WIDTH)
  ) u_middle_line (
    .clk_i   (clk_i),
    .we_i    (s1_leave && s1_wr_q),
    .waddr_i (s1_idx_q),
    .wdata_i (s1_cur_q),
    .re_i    (accept && direction_i),
    .raddr_i (idx),
    .rdata_o (mid_rd)
  );

  assign win_valid_o     = s1_v_q && s1_prod_q;
  assign win_o.lo        = s1_wr_q ? low_eff : s1_l_q;
  assign win_o.mid       = s1_wr_q ? mid_eff : s1_c_q;
  assign win_o.up        = s1_cur_q;
  assign win_o.row_end   = s1_re_q;
  assign win_o.frame_end = s1_fe_q;

endmodule

// File: rtl/core/tvgs_tap.sv
module tvgs_tap import tvgs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     win_valid_i,
  output logic                     win_ready_o,
  input  window_t                  win_i,
  input  mode_e                    mode_i,
  input  logic signed [COEF_W-1:0] side_coef_i,
  input  logic signed [COEF_W-1:0] center_coef_i,
  tvgs_res_if.source               res_o
);

  localparam int unsigned PS_W  = COEF_W + WORD_W + 1;
  localparam int unsigned PC_W  = COEF_W + WORD_W;
  localparam int unsigned SUM_W = PS_W + 2;
  localparam int unsigned Q_W   = SUM_W - FRAC_W;
  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) <<< (FRAC_W - 1);

  logic                      s2_v_q, s3_v_q;
  logic                      s2_en, s3_en;
  logic                      s2_bypass_q;
  logic signed [PS_W-1:0]    s2_ps_q [3];
  logic signed [PC_W-1:0]    s2_pc_q [3];
  vec_t                      s2_mid_q;
  logic                      s2_re_q, s2_fe_q;
  vec_t                      out_q;
  logic                      out_re_q, out_fe_q;

  logic signed [COEF_W-1:0]  side_c, cent_c;
  logic                      bypass;
  logic signed [WORD_W:0]    lu    [3];
  logic signed [PS_W-1:0]    ps_d  [3];
  logic signed [PC_W-1:0]    pc_d  [3];
  logic signed [SUM_W-1:0]   t     [3];
  logic [Q_W-1:0]            q     [3];
  vec_t                      res_d;

  assign s3_en       = !s3_v_q || res_o.ready;
  assign s2_en       = !s2_v_q || s3_en;
  assign win_ready_o = s2_en;

  always_comb begin
    case (mode_i)
      MODE_BINOMIAL: begin
        side_c = BINOM_SIDE;
        cent_c = BINOM_CENTRE;
        bypass = 1'b0;
      end
      MODE_COMPENSATED: begin
        side_c = side_coef_i;
        cent_c = center_coef_i;
        bypass = 1'b0;
      end
      default: begin
        side_c = BINOM_SIDE;
        cent_c = BINOM_CENTRE;
        bypass = 1'b1;
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      lu[k]   = $signed({win_i.lo[k][WORD_W-1], win_i.lo[k]}) +
                $signed({win_i.up[k][WORD_W-1], win_i.up[k]});
      ps_d[k] = side_c * lu[k];
      pc_d[k] = cent_c * $signed(win_i.mid[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t[k] = s2_ps_q[k] + s2_pc_q[k] + ROUND;
      q[k] = t[k][SUM_W-1:FRAC_W];
      if (s2_bypass_q) begin
        res_d[k] = s2_mid_q[k];
      end else if ((&q[k][Q_W-1:WORD_W-1]) || !(|q[k][Q_W-1:WORD_W-1])) begin
        res_d[k] = q[k][WORD_W-1:0];
      end else if (q[k][Q_W-1]) begin
        res_d[k] = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
        res_d[k] = {1'b0, {(WORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s2_en) begin
        s2_v_q <= win_valid_i;
      end
      if (s3_en) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && win_valid_i) begin
      s2_bypass_q <= bypass;
      s2_ps_q     <= ps_d;
      s2_pc_q     <= pc_d;
      s2_mid_q    <= win_i.mid;
      s2_re_q     <= win_i.row_end;
      s2_fe_q     <= win_i.frame_end;
    end
    if (s3_en && s2_v_q) begin
      out_q    <= res_d;
      out_re_q <= s2_re_q;
      out_fe_q <= s2_fe_q;
    end
  end

  assign res_o.valid     = s3_v_q;
  assign res_o.out_x     = out_q[0];
  assign res_o.out_y     = out_q[1];
  assign res_o.out_z     = out_q[2];
  assign res_o.row_end   = out_re_q;
  assign res_o.frame_end = out_fe_q;

endmodule

// File: rtl/core/three_tap_vector_grid_smoother.sv
// a result passes the window stage, tap product and output registers in that order
// throughput: one cell per cycle, line store reads and writes overlap with a bypass path
// ready flows back combinationally, the pipeline stalls only when the result is not taken
// reset: async active low, clears counters, window, valid bits and config to defaults
// line stores are not cleared, no clearing pass after reset
module three_tap_vector_grid_smoother import tvgs_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_ROWS  = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  tvgs_cell_if.sink             cell_i,
  tvgs_res_if.source            res_o
);

  logic                     direction_q;
  mode_e                    mode_q;
  logic [COL_W-1:0]         active_width_q;
  logic [ROW_W-1:0]         active_rows_q;
  logic signed [COEF_W-1:0] side_coef_q, center_coef_q;

  logic    win_valid, win_ready;
  window_t win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q    <= 1'b0;
      mode_q         <= MODE_BYPASS;
      active_width_q <= COL_W'(1);
      active_rows_q  <= ROW_W'(1);
      side_coef_q    <= SIDE_RESET;
      center_coef_q  <= CENTRE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DIRECTION:    direction_q    <= cfg_wdata_i[0];
        REG_FILTER_MODE:  mode_q         <= mode_e'(cfg_wdata_i[MODE_W-1:0]);
        REG_ACTIVE_WIDTH: active_width_q <= cfg_wdata_i[COL_W-1:0];
        REG_ACTIVE_ROWS:  active_rows_q  <= cfg_wdata_i[ROW_W-1:0];
        REG_SIDE_COEF:    side_coef_q    <= $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_CENTER_COEF:  center_coef_q  <= $signed(cfg_wdata_i[COEF_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  tvgs_window #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_ROWS  (MAX_ROWS)
  ) u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cell_i         (cell_i),
    .direction_i    (direction_q),
    .active_width_i (active_width_q),
    .active_rows_i  (active_rows_q),
    .win_valid_o    (win_valid),
    .win_ready_i    (win_ready),
    .win_o          (win)
  );

  tvgs_tap u_tap (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .win_valid_i   (win_valid),
    .win_ready_o   (win_ready),
    .win_i         (win),
    .mode_i        (mode_q),
    .side_coef_i   (side_coef_q),
    .center_coef_i (center_coef_q),
    .res_o         (res_o)
  );

endmodule

// File: bench/three_tap_vector_grid_smoother_tb.sv
module three_tap_vector_grid_smoother_tb import tvgs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W      = 1024;
  localparam int unsigned MAX_AW     = $clog2(MAX_W);
  localparam int unsigned MAX_R      = 4096;
  localparam int unsigned RAND_CELLS = 680;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned TAIL       = 8;

  typedef struct packed {
    vec_t v;
    logic frame_start;
  } grid_cell_t;

  typedef struct packed {
    vec_t v;
    logic row_end;
    logic frame_end;
  } smooth_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tvgs_cell_if cell_if();
  tvgs_res_if  res_if();

  three_tap_vector_grid_smoother #(
    .MAX_WIDTH(MAX_W),
    .MAX_ROWS (MAX_R)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .cell_i     (cell_if.sink),
    .res_o      (res_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic                     cfg_dir    = 1'b0;
  logic [MODE_W-1:0]        cfg_mode   = MODE_BYPASS;
  logic [COL_W-1:0]         cfg_width  = 11'd1;
  logic [ROW_W-1:0]         cfg_rows   = 13'd1;
  logic signed [COEF_W-1:0] cfg_side   = SIDE_RESET;
  logic signed [COEF_W-1:0] cfg_centre = CENTRE_RESET;
  vec_t                     left_q     = '0;
  vec_t                     centre_q   = '0;
  vec_t                     lower_mem  [MAX_W];
  vec_t                     middle_mem [MAX_W];
  int unsigned              col_cnt    = 0;
  int unsigned              row_cnt    = 0;

  grid_cell_t  cell_q [$];
  smooth_res_t smoothed_q [$];
  grid_cell_t  cell_now;
  smooth_res_t res_tmp;
  smooth_res_t got;
  smooth_res_t want;
  bit          produced;
  int unsigned n_cells_queued = 0;
  int unsigned n_cells_taken  = 0;
  int unsigned n_bad          = 0;
  logic        steady         = 1'b0;
  logic        hold_go        = 1'b0;
  int unsigned hold_cnt       = 0;

  function automatic int unsigned eff_width(logic [COL_W-1:0] width);
    if (width == 0) return 1;
    return (width > MAX_W) ? MAX_W : width;
  endfunction

  function automatic int unsigned eff_rows(logic [ROW_W-1:0] rows);
    if (rows == 0) return 1;
    return (rows > MAX_R) ? MAX_R : rows;
  endfunction

  function automatic int unsigned frame_cells(logic dir, logic [COL_W-1:0] width,
                                              logic [ROW_W-1:0] rows);
    int unsigned w;
    int unsigned r;
    w = eff_width(width);
    r = eff_rows(rows);
    return dir ? w * (r + 2) : (w + 2) * (r + 3);
  endfunction

  function automatic logic [WORD_W-1:0] tap3_round(input logic [WORD_W-1:0] lo, mid, up,
                                                   input logic signed [COEF_W-1:0] ks, kc);
    longint acc;
    acc = longint'(ks) * longint'($signed(lo)) + longint'(kc) * longint'($signed(mid))
        + longint'(ks) * longint'($signed(up)) + 64'sd8192;
    acc = acc >>> FRAC_W;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[WORD_W-1:0];
  endfunction

  function automatic bit smooth_cell(input grid_cell_t c, output smooth_res_t r);
    int unsigned       w;
    int unsigned       len;
    int unsigned       nrows;
    logic [MAX_AW-1:0] idx;
    int                k;
    bit                lastc;
    bit                lastr;
    bit                hit;
    vec_t              lo;
    vec_t              mid;
    hit = 1'b0;
    lo  = '0;
    mid = '0;
    if (c.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    w = eff_width(cfg_width);
    if (!cfg_dir) begin
      len   = w + 2;
      nrows = eff_rows(cfg_rows) + 3;
    end else begin
      len   = w;
      nrows = eff_rows(cfg_rows) + 2;
    end
    lastc = col_cnt >= len - 1;
    lastr = row_cnt >= nrows - 1;
    if (!cfg_dir) begin
      if (col_cnt >= 2) begin
        hit = 1'b1;
        lo  = left_q;
        mid = centre_q;
      end
      left_q   = centre_q;
      centre_q = c.v;
    end else begin
      idx = MAX_AW'((col_cnt < w) ? col_cnt : w - 1);
      if (row_cnt >= 2) begin
        hit = 1'b1;
        lo  = lower_mem[idx];
        mid = middle_mem[idx];
      end
      lower_mem[idx]  = middle_mem[idx];
      middle_mem[idx] = c.v;
    end
    if (lastc) begin
      col_cnt = 0;
      row_cnt = lastr ? 0 : ((row_cnt + 1) & 32'h1FFF);
    end else begin
      col_cnt = (col_cnt + 1) & 32'h7FF;
    end
    for (k = 0; k < 3; k++) begin
      case (cfg_mode)
        MODE_BINOMIAL:    r.v[k] = tap3_round(lo[k], mid[k], c.v[k], BINOM_SIDE, BINOM_CENTRE);
        MODE_COMPENSATED: r.v[k] = tap3_round(lo[k], mid[k], c.v[k], cfg_side, cfg_centre);
        default:          r.v[k] = mid[k];
      endcase
    end
    r.row_end   = lastc;
    r.frame_end = lastc && lastr;
    return hit;
  endfunction

  // cell driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cell_if.valid && cell_if.ready) begin
        produced = smooth_cell(cell_now, res_tmp);
        if (produced) smoothed_q.push_back(res_tmp);
        n_cells_taken++;
      end
      if (!cell_if.valid || cell_if.ready) begin
        if (cell_q.size() != 0 && (steady || $urandom_range(0, 99) >= 37)) begin
          cell_now = cell_q.pop_front();
          cell_if.valid       <= 1'b1;
          cell_if.cell_x      <= cell_now.v[0];
          cell_if.cell_y      <= cell_now.v[1];
          cell_if.cell_z      <= cell_now.v[2];
          cell_if.frame_start <= cell_now.frame_start;
        end else begin
          cell_if.valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off of the result side
  always @(posedge clk_i) begin
    if (hold_go) hold_cnt <= HOLD_LEN;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got.v[0]      = res_if.out_x;
        got.v[1]      = res_if.out_y;
        got.v[2]      = res_if.out_z;
        got.row_end   = res_if.row_end;
        got.frame_end = res_if.frame_end;
        if (smoothed_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected word: %h %h %h re=%b fe=%b",
                     got.v[0], got.v[1], got.v[2], got.row_end, got.frame_end);
        end else begin
          want = smoothed_q.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("word mismatch: exp %h %h %h re=%b fe=%b, got %h %h %h re=%b fe=%b",
                       want.v[0], want.v[1], want.v[2], want.row_end, want.frame_end,
                       got.v[0], got.v[1], got.v[2], got.row_end, got.frame_end);
          end
        end
      end
      res_if.ready <= (hold_cnt == 0) && (steady || $urandom_range(0, 99) >= 37);
    end
  end

  function automatic logic [WORD_W-1:0] pick_word(bit edge_only);
    int unsigned sel;
    sel = edge_only ? $urandom_range(0, 4) : $urandom_range(0, 15);
    case (sel)
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0001_0000;
      5, 6, 7: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return -18'sd131072;
      1:       return 18'sd131071;
      2:       return 18'sd0;
      3:       return COEF_W'($urandom_range(0, 40960)) - 18'sd8192;
      default: return COEF_W'($urandom());
    endcase
  endfunction

  task automatic cfg_write(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  task automatic configure(logic dir, logic [MODE_W-1:0] mode, logic [COL_W-1:0] width,
                           logic [ROW_W-1:0] rows, logic signed [COEF_W-1:0] side,
                           logic signed [COEF_W-1:0] centre);
    cfg_write(REG_DIRECTION, dir);
    cfg_write(REG_FILTER_MODE, mode);
    cfg_write(REG_ACTIVE_WIDTH, width);
    cfg_write(REG_ACTIVE_ROWS, rows);
    cfg_write(REG_SIDE_COEF, side);
    cfg_write(REG_CENTER_COEF, centre);
    cfg_we     <= 1'b0;
    cfg_dir    = dir;
    cfg_mode   = mode;
    cfg_width  = width;
    cfg_rows   = rows;
    cfg_side   = side;
    cfg_centre = centre;
  endtask

  task automatic queue_cells(int unsigned n, bit first_fs, int unsigned flen,
                             int unsigned noise_pm, bit edge_only);
    grid_cell_t  c;
    int unsigned i;
    for (i = 0; i < n; i++) begin
      c.v[0] = pick_word(edge_only);
      c.v[1] = pick_word(edge_only);
      c.v[2] = pick_word(edge_only);
      c.frame_start = (i == 0 && first_fs)
                   || (flen != 0 && i != 0 && i % flen == 0 && $urandom_range(0, 1) == 1)
                   || ($urandom_range(0, 999) < noise_pm);
      cell_q.push_back(c);
      n_cells_queued++;
    end
  endtask

  // wait until every cell is taken and every word is back, then let the pipe empty
  task automatic settle();
    while (n_cells_taken != n_cells_queued || smoothed_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
  endtask

  initial begin
    logic                     dir;
    logic [MODE_W-1:0]        mode;
    logic [COL_W-1:0]         width;
    logic [ROW_W-1:0]         rows;
    int unsigned              flen;
    int unsigned              n;
    int unsigned              noise;
    int unsigned              n_rand;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_DIRECTION;
    cfg_wdata           = '0;
    cell_if.valid       = 1'b0;
    cell_if.cell_x      = '0;
    cell_if.cell_y      = '0;
    cell_if.cell_z      = '0;
    cell_if.frame_start = 1'b0;
    res_if.ready        = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // x bypass at reset sizes, then saturating compensated taps
    queue_cells(12, 1'b1, 12, 0, 1'b1);
    settle();
    configure(1'b0, MODE_COMPENSATED, 11'd1, 13'd1, -18'sd131072, 18'sd131071);
    queue_cells(12, 1'b1, 12, 0, 1'b1);
    settle();

    // y binomial, unused mode, zero sizes wrapping without frame start, then compensated
    configure(1'b1, MODE_BINOMIAL, 11'd2, 13'd1, SIDE_RESET, CENTRE_RESET);
    queue_cells(6, 1'b1, 6, 0, 1'b1);
    settle();
    configure(1'b1, 2'd3, 11'd0, 13'd0, SIDE_RESET, CENTRE_RESET);
    queue_cells(6, 1'b1, 0, 0, 1'b1);
    settle();
    configure(1'b1, MODE_COMPENSATED, 11'd2, 13'd2, 18'sd131071, -18'sd131072);
    queue_cells(8, 1'b1, 8, 0, 1'b1);
    settle();

    // counters left beyond the new row and frame length
    configure(1'b0, MODE_BINOMIAL, 11'd3, 13'd2, SIDE_RESET, CENTRE_RESET);
    queue_cells(24, 1'b1, 25, 0, 1'b0);
    settle();
    configure(1'b0, MODE_BINOMIAL, 11'd1, 13'd0, SIDE_RESET, CENTRE_RESET);
    queue_cells(4, 1'b0, 0, 0, 1'b0);
    settle();

    // direction flips inside a frame
    configure(1'b1, MODE_BYPASS, 11'd2, 13'd2, SIDE_RESET, CENTRE_RESET);
    queue_cells(6, 1'b0, 0, 0, 1'b0);
    settle();
    configure(1'b0, MODE_BINOMIAL, 11'd2, 13'd2, SIDE_RESET, CENTRE_RESET);
    queue_cells(6, 1'b0, 0, 0, 1'b0);
    settle();

    // oversized width with a long output hold-off and no idling, then oversized row count
    configure(1'b0, MODE_COMPENSATED, 11'd2047, 13'd1, SIDE_RESET, CENTRE_RESET);
    steady <= 1'b1;
    queue_cells(1030, 1'b1, 0, 0, 1'b0);
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    settle();
    steady <= 1'b0;
    configure(1'b1, MODE_BINOMIAL, 11'd1, 13'd8191, SIDE_RESET, CENTRE_RESET);
    queue_cells(8, 1'b1, 0, 0, 1'b0);
    settle();

    n_rand = 0;
    while (n_rand < RAND_CELLS) begin
      dir  = 1'($urandom_range(0, 1));
      mode = MODE_W'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:             width = 11'd0;
        1, 2, 3, 4, 5: width = COL_W'($urandom_range(1, 4));
        6, 7, 8:       width = COL_W'($urandom_range(5, 16));
        default:       width = COL_W'($urandom_range(17, 40));
      endcase
      rows = ROW_W'(($urandom_range(0, 4) == 0) ? $urandom_range(6, 10)
                                                : $urandom_range(0, 5));
      configure(dir, mode, width, rows, pick_coef(), pick_coef());
      flen = frame_cells(dir, width, rows);
      if ($urandom_range(0, 9) < 7) begin
        n     = flen * $urandom_range(1, 3);
        noise = 0;
      end else begin
        n     = $urandom_range(1, flen * 2);
        noise = 15;
      end
      if (n > 400) n = 400;
      if (n > RAND_CELLS - n_rand) n = RAND_CELLS - n_rand;
      queue_cells(n, 1'b1, flen, noise, 1'b0);
      n_rand += n;
      settle();
    end
    steady <= 1'b0;
    settle();

    if (n_bad == 0) begin
      $display("three_tap_vector_grid_smoother verification clean");
    end else begin
      $display("three_tap_vector_grid_smoother verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("three_tap_vector_grid_smoother verification failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/tvgs_pkg.sv
rtl/core/tvgs_if.sv
rtl/core/tvgs_ram.sv
rtl/core/tvgs_window.sv
rtl/core/tvgs_tap.sv
rtl/core/three_tap_vector_grid_smoother.sv
bench/three_tap_vector_grid_smoother_tb.sv
